@@ design/tpc_pkg.sv @@
// ============================================================================
// tpc_pkg
// Shared constants for the timer prescale and compare calculator.
// ============================================================================
package tpc_pkg;

   localparam int NUM_PRESCALE = 5;

   // Divide ratios 1, 8, 64, 256 and 1024 as right shifts
   localparam int PRESCALE_SHIFT [NUM_PRESCALE] = '{0, 3, 6, 8, 10};

   typedef enum logic [2:0] {
      CODE_NONE  = 3'd0,
      CODE_DIV1  = 3'd1,
      CODE_DIV8  = 3'd2,
      CODE_DIV64 = 3'd3,
      CODE_DIV256 = 3'd4,
      CODE_DIV1024 = 3'd5
   } prescale_code_type;

   localparam prescale_code_type PRESCALE_CODE [NUM_PRESCALE] =
      '{CODE_DIV1, CODE_DIV8, CODE_DIV64, CODE_DIV256, CODE_DIV1024};

   localparam logic [15:0] CAP_NARROW = 16'd255;
   localparam logic [15:0] CAP_WIDE   = 16'd65535;

   localparam int US_PER_S   = 1000000;
   localparam int VALUE_W    = 32;
   localparam int RESULT_W   = 16;

endpackage

@@ design/tpc_div_cell.sv @@
// ============================================================================
// tpc_div_cell
// One restoring-division step for two lanes, plus the word riding alongside.
// ============================================================================
module tpc_div_cell #(
   parameter int         DIV_W   = 24,
   parameter logic       DVD_BIT = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic                          in_mode,
   input  logic [tpc_pkg::VALUE_W-1:0]   in_prim,
   input  logic [tpc_pkg::VALUE_W-1:0]   in_sec,
   input  logic [tpc_pkg::VALUE_W-1:0]   in_rem_a,
   input  logic [DIV_W-1:0]              in_q_a,
   input  logic [tpc_pkg::VALUE_W-1:0]   in_rem_b,
   input  logic [DIV_W-1:0]              in_q_b,
   output logic                          out_valid,
   output logic                          out_mode,
   output logic [tpc_pkg::VALUE_W-1:0]   out_prim,
   output logic [tpc_pkg::VALUE_W-1:0]   out_sec,
   output logic [tpc_pkg::VALUE_W-1:0]   out_rem_a,
   output logic [DIV_W-1:0]              out_q_a,
   output logic [tpc_pkg::VALUE_W-1:0]   out_rem_b,
   output logic [DIV_W-1:0]              out_q_b
);

   localparam int VW = tpc_pkg::VALUE_W;

   logic          valid_ff;
   logic          mode_ff;
   logic [VW-1:0] prim_ff, sec_ff, rem_a_ff, rem_b_ff;
   logic [DIV_W-1:0] q_a_ff, q_b_ff;

   logic [VW:0]   shift_a, shift_b;
   logic [VW+1:0] diff_a, diff_b;
   logic          ge_a, ge_b;
   logic [VW-1:0] rem_a_in, rem_b_in;
   logic [DIV_W-1:0] q_a_in, q_b_in;

   always_comb begin
      shift_a  = {in_rem_a, DVD_BIT};
      shift_b  = {in_rem_b, DVD_BIT};
      diff_a   = {1'b0, shift_a} - {2'b00, in_prim};
      diff_b   = {1'b0, shift_b} - {2'b00, in_sec};
      ge_a     = !diff_a[VW+1];
      ge_b     = !diff_b[VW+1];
      rem_a_in = ge_a ? diff_a[VW-1:0] : shift_a[VW-1:0];
      rem_b_in = ge_b ? diff_b[VW-1:0] : shift_b[VW-1:0];
      q_a_in   = {in_q_a[DIV_W-2:0], ge_a};
      q_b_in   = {in_q_b[DIV_W-2:0], ge_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff  <= in_mode;
         prim_ff  <= in_prim;
         sec_ff   <= in_sec;
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         q_a_ff   <= q_a_in;
         q_b_ff   <= q_b_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_prim  = prim_ff;
   assign out_sec   = sec_ff;
   assign out_rem_a = rem_a_ff;
   assign out_rem_b = rem_b_ff;
   assign out_q_a   = q_a_ff;
   assign out_q_b   = q_b_ff;

endmodule

@@ design/tpc_select.sv @@
// ============================================================================
// tpc_select
// Tick counts per prescaler, first-fit pick and second compare value.
// ============================================================================
module tpc_select #(
   parameter int DIV_W        = 24,
   parameter int TW           = 37,
   parameter int TICKS_PER_US = 16
) (
   input  logic                           wide,
   input  logic                           mode,
   input  logic [tpc_pkg::VALUE_W-1:0]    prim,
   input  logic [tpc_pkg::VALUE_W-1:0]    sec,
   input  logic [DIV_W-1:0]               q_a,
   input  logic [DIV_W-1:0]               q_b,
   output logic [tpc_pkg::RESULT_W-1:0]   top_count,
   output logic [tpc_pkg::RESULT_W-1:0]   second_compare,
   output tpc_pkg::prescale_code_type     prescale_code,
   output logic                           no_fit
);

   localparam int RW = tpc_pkg::RESULT_W;

   logic [TW-1:0] ticks [tpc_pkg::NUM_PRESCALE];
   logic [RW-1:0] sec_ticks [tpc_pkg::NUM_PRESCALE];
   logic          fit [tpc_pkg::NUM_PRESCALE];
   logic [TW-1:0] cap;

   always_comb begin
      cap = wide ? TW'(tpc_pkg::CAP_WIDE) : TW'(tpc_pkg::CAP_NARROW);
      for (int i = 0; i < tpc_pkg::NUM_PRESCALE; i++) begin
         if (mode) begin
            ticks[i]     = TW'(TICKS_PER_US) * TW'(prim >> tpc_pkg::PRESCALE_SHIFT[i]);
            sec_ticks[i] = RW'(RW'(TICKS_PER_US) * RW'(sec >> tpc_pkg::PRESCALE_SHIFT[i]));
         end else begin
            // Zero frequency is a zero divisor: no ticks at all
            ticks[i]     = (prim == '0) ? '0 : TW'(q_a >> tpc_pkg::PRESCALE_SHIFT[i]);
            sec_ticks[i] = RW'(q_b >> tpc_pkg::PRESCALE_SHIFT[i]);
         end
         fit[i] = (ticks[i] != '0) && (ticks[i] <= cap);
      end

      top_count      = '0;
      second_compare = '0;
      prescale_code  = tpc_pkg::CODE_NONE;
      no_fit         = 1'b1;
      // Walk from the slowest up so the smallest fitting divider wins
      for (int i = tpc_pkg::NUM_PRESCALE - 1; i >= 0; i--) begin
         if (fit[i]) begin
            top_count      = RW'(ticks[i] - TW'(1));
            second_compare = sec_ticks[i] - RW'(1);
            prescale_code  = tpc_pkg::PRESCALE_CODE[i];
            no_fit         = 1'b0;
         end
      end
      if (top_count == '0 || sec == '0) begin
         second_compare = '0;
      end
   end

endmodule

@@ design/timer_prescale_compare_calc.sv @@
// ============================================================================
// timer_prescale_compare_calc
// Picks a timer prescaler and compare values from a frequency or a period.
// ============================================================================
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | req_valid, req_stall, req_type,         | in
//           | req_primary_value, req_secondary_value  |
//  response | rsp_valid, rsp_stall, rsp_top_count,    | out
//           | rsp_second_compare, rsp_prescale_code,  |
//           | rsp_no_fit                              |
//  config   | csr_wr_en, csr_wr_data (wide_timer)     | in
//
// A word is taken every cycle unless rsp_stall holds a finished word;
// it passes through the row of division cells, one per bit of CLOCK_HZ,
// that forms CLOCK_HZ / value for both values side by side.
// Reset clears all valid flags and the wide_timer register.
// A response word held by rsp_stall freezes the whole row and stalls the
// request side with it; bubbles inside the row are not squeezed out.
//
module timer_prescale_compare_calc #(
   parameter int CLOCK_HZ = 16000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_primary_value,
   input  logic [31:0] req_secondary_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_top_count,
   output logic [15:0] rsp_second_compare,
   output logic [2:0]  rsp_prescale_code,
   output logic        rsp_no_fit,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int DIV_W        = $clog2(CLOCK_HZ + 1);
   localparam int TICKS_PER_US = CLOCK_HZ / tpc_pkg::US_PER_S;
   localparam int MUL_W        = $clog2(TICKS_PER_US + 1);
   localparam int TW           = tpc_pkg::VALUE_W + MUL_W;
   localparam logic [DIV_W-1:0] DVD = DIV_W'(CLOCK_HZ);
   localparam int VW           = tpc_pkg::VALUE_W;
   localparam int RW           = tpc_pkg::RESULT_W;

   logic wide_timer_ff;
   logic advance;

   // stage k is the input of cell k; stage DIV_W is the row's output
   logic             s_valid [DIV_W+1];
   logic             s_mode  [DIV_W+1];
   logic [VW-1:0]    s_prim  [DIV_W+1];
   logic [VW-1:0]    s_sec   [DIV_W+1];
   logic [VW-1:0]    s_rem_a [DIV_W+1];
   logic [VW-1:0]    s_rem_b [DIV_W+1];
   logic [DIV_W-1:0] s_q_a   [DIV_W+1];
   logic [DIV_W-1:0] s_q_b   [DIV_W+1];

   logic                          rsp_valid_ff;
   logic [RW-1:0]                 top_ff, second_ff;
   tpc_pkg::prescale_code_type    code_ff;
   logic                          no_fit_ff;

   logic [RW-1:0]                 sel_top, sel_second;
   tpc_pkg::prescale_code_type    sel_code;
   logic                          sel_no_fit;

   // Hold everything while a finished word waits to be taken
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_timer_ff <= 1'b0;
      end else if (csr_wr_en) begin
         wide_timer_ff <= csr_wr_data;
      end
   end

   assign s_valid[0] = req_valid;
   assign s_mode[0]  = req_type;
   assign s_prim[0]  = req_primary_value;
   assign s_sec[0]   = req_secondary_value;
   assign s_rem_a[0] = '0;
   assign s_rem_b[0] = '0;
   assign s_q_a[0]   = '0;
   assign s_q_b[0]   = '0;

   // One cell per dividend bit, most significant first
   for (genvar k = 0; k < DIV_W; k++) begin : g_cell
      tpc_div_cell #(
         .DIV_W   (DIV_W),
         .DVD_BIT (DVD[DIV_W-1-k])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (s_valid[k]),
         .in_mode   (s_mode[k]),
         .in_prim   (s_prim[k]),
         .in_sec    (s_sec[k]),
         .in_rem_a  (s_rem_a[k]),
         .in_q_a    (s_q_a[k]),
         .in_rem_b  (s_rem_b[k]),
         .in_q_b    (s_q_b[k]),
         .out_valid (s_valid[k+1]),
         .out_mode  (s_mode[k+1]),
         .out_prim  (s_prim[k+1]),
         .out_sec   (s_sec[k+1]),
         .out_rem_a (s_rem_a[k+1]),
         .out_q_a   (s_q_a[k+1]),
         .out_rem_b (s_rem_b[k+1]),
         .out_q_b   (s_q_b[k+1])
      );
   end

   tpc_select #(
      .DIV_W        (DIV_W),
      .TW           (TW),
      .TICKS_PER_US (TICKS_PER_US)
   ) u_select (
      .wide           (wide_timer_ff),
      .mode           (s_mode[DIV_W]),
      .prim           (s_prim[DIV_W]),
      .sec            (s_sec[DIV_W]),
      .q_a            (s_q_a[DIV_W]),
      .q_b            (s_q_b[DIV_W]),
      .top_count      (sel_top),
      .second_compare (sel_second),
      .prescale_code  (sel_code),
      .no_fit         (sel_no_fit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s_valid[DIV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         top_ff    <= sel_top;
         second_ff <= sel_second;
         code_ff   <= sel_code;
         no_fit_ff <= sel_no_fit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_top_count      = top_ff;
   assign rsp_second_compare = second_ff;
   assign rsp_prescale_code  = code_ff;
   assign rsp_no_fit         = no_fit_ff;

   // An accepted request must land in the first cell
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s_valid[1])
      else $error("accepted request did not enter the cell row");

   // No fit and a zero code go together
   a_nofit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_no_fit == (rsp_prescale_code == tpc_pkg::CODE_NONE)))
      else $error("no_fit disagrees with prescale code");

   // A zero top count never carries a second compare
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_top_count == '0 |-> rsp_second_compare == '0)
      else $error("second compare set with zero top count");

endmodule

@@ verif/timer_prescale_compare_checker.sv @@
// ============================================================================
// timer_prescale_compare_checker
// Watches the request, response and register ports of the prescale
// calculator, predicts every response word and compares it field by field.
// ============================================================================
module timer_prescale_compare_checker #(
   parameter int CLOCK_HZ = 16000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_primary_value,
   input  logic [31:0] req_secondary_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_top_count,
   input  logic [15:0] rsp_second_compare,
   input  logic [2:0]  rsp_prescale_code,
   input  logic        rsp_no_fit,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0]                top_count;
      logic [15:0]                second_compare;
      tpc_pkg::prescale_code_type prescale_code;
      logic                       no_fit;
   } timer_setting_type;

   timer_setting_type setting_queue [$];
   logic              wide_cap;

   // Ticks per period at divide ratio 2**shift; period mode scales microseconds
   function automatic longint unsigned tick_count(logic period_mode,
                                                  logic [31:0] value, int shift);
      longint unsigned ratio;
      ratio = 64'd1 << shift;
      if (period_mode)
         return longint'(CLOCK_HZ / tpc_pkg::US_PER_S) * (longint'(value) / ratio);
      if (value == 0)
         return 0;
      return (longint'(CLOCK_HZ) / ratio) / longint'(value);
   endfunction

   function automatic timer_setting_type pick_prescaler(logic period_mode,
                                                        logic [31:0] primary,
                                                        logic [31:0] secondary,
                                                        logic wide);
      timer_setting_type s;
      longint unsigned   ticks;
      longint unsigned   cap;
      s = '{top_count: '0, second_compare: '0, prescale_code: tpc_pkg::CODE_NONE,
            no_fit: 1'b1};
      cap = wide ? longint'(tpc_pkg::CAP_WIDE) : longint'(tpc_pkg::CAP_NARROW);
      for (int i = 0; i < tpc_pkg::NUM_PRESCALE; i++) begin
         ticks = tick_count(period_mode, primary, tpc_pkg::PRESCALE_SHIFT[i]);
         if (ticks >= 1 && ticks - 1 < cap) begin
            s.top_count     = 16'(ticks - 1);
            s.prescale_code = tpc_pkg::PRESCALE_CODE[i];
            s.no_fit        = 1'b0;
            if (secondary != 0 && s.top_count != 0)
               s.second_compare = 16'(tick_count(period_mode, secondary,
                                                 tpc_pkg::PRESCALE_SHIFT[i]) - 1);
            break;
         end
      end
      return s;
   endfunction

   always @(posedge clock) begin
      timer_setting_type want;
      if (reset) begin
         wide_cap <= 1'b0;
         setting_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            wide_cap <= csr_wr_data;
         if (req_valid && !req_stall)
            setting_queue.push_back(pick_prescaler(req_type, req_primary_value,
                                                   req_secondary_value, wide_cap));
         if (rsp_valid && !rsp_stall) begin
            if (setting_queue.size() == 0) begin
               $error("unexpected response word");
               fail_count++;
            end else begin
               want = setting_queue.pop_front();
               if (rsp_top_count !== want.top_count) begin
                  $error("top_count: expected %0d, got %0d", want.top_count, rsp_top_count);
                  fail_count++;
               end
               if (rsp_second_compare !== want.second_compare) begin
                  $error("second_compare: expected %0d, got %0d",
                         want.second_compare, rsp_second_compare);
                  fail_count++;
               end
               if (rsp_prescale_code !== want.prescale_code) begin
                  $error("prescale_code: expected %0d, got %0d",
                         want.prescale_code, rsp_prescale_code);
                  fail_count++;
               end
               if (rsp_no_fit !== want.no_fit) begin
                  $error("no_fit: expected %0d, got %0d", want.no_fit, rsp_no_fit);
                  fail_count++;
               end
            end
         end
      end
      pending_count = setting_queue.size();
   end

endmodule

@@ verif/timer_prescale_compare_calc_tb.sv @@
// ============================================================================
// timer_prescale_compare_calc_tb
// Drives directed and random requests with random gaps and response stalls
// through the prescale calculator, in both timer widths; the checker beside
// the block predicts and compares, and this top gives the verdict.
// ============================================================================
module timer_prescale_compare_calc_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HZ    = 16000000;
   localparam int SETTLE      = 40;     // beyond the pipeline depth
   localparam int IDLE_LIMIT  = 2000;   // cycles with no word moving
   localparam int RANDOM_ITEMS = 1000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [31:0] req_primary_value;
   logic [31:0] req_secondary_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_top_count;
   logic [15:0] rsp_second_compare;
   logic [2:0]  rsp_prescale_code;
   logic        rsp_no_fit;
   logic        csr_wr_en;
   logic        csr_wr_data;
   int          fail_count;
   int          pending_count;
   bit          quiet_stretch;   // both sides run without idling
   int          idle_cycles;

   timer_prescale_compare_calc #(.CLOCK_HZ(CLOCK_HZ)) DUT (.*);

   timer_prescale_compare_checker #(.CLOCK_HZ(CLOCK_HZ)) checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timer_prescale_compare_calc regression: fail");
         $finish;
      end
   end

   // Response side: hold stall high for a random number of cycles per word
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = quiet_stretch ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   // Drive one request word and hold it until the block takes it
   task automatic send_word(logic period_mode, logic [31:0] primary,
                            logic [31:0] secondary);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= period_mode;
      req_primary_value   <= primary;
      req_secondary_value <= secondary;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Drop valid, drain the pipeline and write the width register while idle
   task automatic set_width(logic wide);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= wide;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Values spread over all magnitudes so that every prescaler gets chosen
   function automatic logic [31:0] spread_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 40);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic directed_words();
      send_word(1'b0, 32'd0, 32'd0);               // zero frequency
      send_word(1'b0, 32'd0, 32'd1000);
      send_word(1'b0, 32'd1, 32'd1);               // far too slow: nothing fits in the narrow timer
      send_word(1'b0, CLOCK_HZ, 32'd5);            // single tick, top count zero
      send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // zero ticks everywhere
      send_word(1'b0, 32'd62500, 32'd125000);      // edge of the narrow cap
      send_word(1'b0, 32'd62745, 32'd0);
      send_word(1'b0, 32'd245, 32'd1);
      send_word(1'b0, 32'd1000, 32'hFFFF_FFFF);    // second value wraps
      send_word(1'b0, 32'd61, 32'd7);
      send_word(1'b0, 32'd60, 32'd400);
      send_word(1'b1, 32'd0, 32'd0);               // zero period
      send_word(1'b1, 32'd1, 32'd1);
      send_word(1'b1, 32'd16, 32'd3);
      send_word(1'b1, 32'd17, 32'd100000);
      send_word(1'b1, 32'd4096, 32'd7);            // second value gives zero ticks
      send_word(1'b1, 32'd4095, 32'hFFFF_FFFF);
      send_word(1'b1, 32'd4194304, 32'd1000);
      send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b1, 32'h0000_FFFF, 32'h5555_5555);
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_type            = 1'b0;
      req_primary_value   = '0;
      req_secondary_value = '0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      quiet_stretch       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words in each width, then random phases alternating widths
      set_width(1'b0);
      directed_words();
      set_width(1'b1);
      directed_words();
      for (int phase = 0; phase < 4; phase++) begin
         set_width(phase[0]);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            if (n % 50 == 0)
               quiet_stretch = ($urandom_range(0, 3) == 0);
            send_word(1'($urandom_range(0, 1)), spread_value(),
                      ($urandom_range(0, 4) == 0) ? 32'd0 : spread_value());
         end
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("timer_prescale_compare_calc regression: pass");
      else
         $display("timer_prescale_compare_calc regression: fail");
      $finish;
   end

endmodule

@@ timer_prescale_compare_calc.f @@
design/tpc_pkg.sv
design/tpc_div_cell.sv
design/tpc_select.sv
design/timer_prescale_compare_calc.sv
verif/timer_prescale_compare_checker.sv
verif/timer_prescale_compare_calc_tb.sv
